[rtl/pmd_pkg.sv]
// shared types and constants for the dense prim spanning tree unit
// no dependencies; used by pmd_ctrl, pmd_dp and prim_mst_dense_unit
package pmd_pkg;

    // default sizing
    localparam int DEF_MAX_VERTS   = 16;
    localparam int DEF_WEIGHT_BITS = 8;

    // fixed port widths
    localparam int IN_BITS       = 8;
    localparam int VERT_BITS     = 4;
    localparam int OUT_W_BITS    = 8;
    localparam int COST_BITS     = 12;
    localparam int NV_BITS       = 5;
    localparam int START_BITS    = 4;
    localparam int LIMIT_BITS    = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    // register reset values and limits
    localparam logic [NV_BITS-1:0]    NV_RESET    = 5'd16;
    localparam logic [START_BITS-1:0] START_RESET = 4'd0;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd100;
    localparam logic [COST_BITS-1:0]  COST_MAX    = 12'hFFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NUM_VERTICES = 2'd0,
        REG_START_VERTEX = 2'd1,
        REG_WEIGHT_LIMIT = 2'd2
    } reg_idx_t;

    // controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_TAIL,
        ST_EMIT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic init;
        logic issue;
        logic emit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic load_final;
        logic bad_start;
        logic scan_end;
        logic found;
        logic last_edge;
        logic out_free;
    } stat_t;

endpackage

[rtl/pmd_ctrl.sv]
// sequencer for the dense prim unit: load, setup, scan and tail compare per edge, emit
// depends on pmd_pkg
module pmd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  pmd_pkg::stat_t stat,
    output pmd_pkg::cmd_t  cmd
);

    pmd_pkg::state_t state_reg;
    pmd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmd_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmd_pkg::ST_LOAD:
            begin
                if (item_valid && stat.load_final)
                begin
                    state_next = pmd_pkg::ST_INIT;
                end
            end
            pmd_pkg::ST_INIT:
            begin
                // bad start vertex goes straight to the flagged result
                state_next = stat.bad_start ? pmd_pkg::ST_EMIT : pmd_pkg::ST_SCAN;
            end
            pmd_pkg::ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = pmd_pkg::ST_TAIL;
                end
            end
            pmd_pkg::ST_TAIL:
            begin
                state_next = pmd_pkg::ST_EMIT;
            end
            pmd_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (!stat.found || stat.last_edge)
                    begin
                        state_next = pmd_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = pmd_pkg::ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = pmd_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        item_stall = 1'b1;
        cmd        = '0;
        case (state_reg)
            pmd_pkg::ST_LOAD:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid;
            end
            pmd_pkg::ST_INIT:
            begin
                cmd.init = 1'b1;
            end
            pmd_pkg::ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            pmd_pkg::ST_TAIL:
            begin
                cmd = '0;
            end
            pmd_pkg::ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/pmd_dp.sv]
// datapath of the dense prim unit: config registers, weight memory,
// scan counters, best-edge compare, tree state and result register; uses pmd_pkg
module pmd_dp #(
    parameter int MAX_VERTS   = pmd_pkg::DEF_MAX_VERTS,
    parameter int WEIGHT_BITS = pmd_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pmd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [pmd_pkg::IN_BITS-1:0]         edge_weight_in,
    input  pmd_pkg::cmd_t                       cmd,
    output pmd_pkg::stat_t                      stat,
    input  logic                                result_stall,
    output logic                                result_valid,
    output logic [pmd_pkg::VERT_BITS-1:0]       src_vertex,
    output logic [pmd_pkg::VERT_BITS-1:0]       dst_vertex,
    output logic [pmd_pkg::OUT_W_BITS-1:0]      chosen_weight,
    output logic [pmd_pkg::COST_BITS-1:0]       total_cost,
    output logic                                unreachable,
    output logic                                last
);

    localparam int VB    = (MAX_VERTS > 2) ? $clog2(MAX_VERTS) : 1;
    localparam int NB    = $clog2(MAX_VERTS + 1);
    localparam int DEPTH = MAX_VERTS * MAX_VERTS;
    localparam int AB    = $clog2(DEPTH);
    localparam int LW    = 2 * NB + 1;
    localparam int CW    = WEIGHT_BITS + pmd_pkg::LIMIT_BITS;
    localparam int SW    = WEIGHT_BITS + pmd_pkg::COST_BITS + 1;

    // configuration
    logic [pmd_pkg::NV_BITS-1:0]    nv_reg;
    logic [pmd_pkg::START_BITS-1:0] start_reg;
    logic [pmd_pkg::LIMIT_BITS-1:0] limit_reg;

    // loading and tree state
    logic [AB-1:0]                  load_cnt_reg, load_cnt_next;
    logic [MAX_VERTS-1:0]           visited_reg, visited_next;
    logic [pmd_pkg::COST_BITS-1:0]  cost_reg, cost_next;
    logic [VB-1:0]                  edges_reg, edges_next;

    // scan counters and compare stage
    logic [VB-1:0]                  i_reg, i_next;
    logic [VB-1:0]                  j_reg, j_next;
    logic [AB-1:0]                  addr_reg, addr_next;
    logic                           tag_valid_reg;
    logic [VB-1:0]                  tag_i_reg;
    logic [VB-1:0]                  tag_j_reg;
    logic [WEIGHT_BITS-1:0]         rd_reg;
    logic                           found_reg, found_next;
    logic [VB-1:0]                  best_i_reg, best_i_next;
    logic [VB-1:0]                  best_j_reg, best_j_next;
    logic [WEIGHT_BITS-1:0]         best_w_reg, best_w_next;

    // result register
    logic                           res_valid_reg, res_valid_next;
    logic [pmd_pkg::VERT_BITS-1:0]  res_src_reg;
    logic [pmd_pkg::VERT_BITS-1:0]  res_dst_reg;
    logic [pmd_pkg::OUT_W_BITS-1:0] res_w_reg;
    logic [pmd_pkg::COST_BITS-1:0]  res_cost_reg;
    logic                           res_unr_reg;
    logic                           res_last_reg;

    logic [WEIGHT_BITS-1:0]         mem [DEPTH];

    logic [NB-1:0]                  n;
    logic [VB-1:0]                  nm1;
    logic [2*NB-1:0]                n_sq;
    logic [WEIGHT_BITS-1:0]         w_in;
    logic                           eligible;
    logic                           take;
    logic [SW-1:0]                  sum;
    logic [pmd_pkg::COST_BITS-1:0]  cost_sat;
    logic                           cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // vertex count clamped to the supported range
    always_comb
    begin
        if (int'(nv_reg) < 2)
        begin
            n = NB'(2);
        end
        else if (int'(nv_reg) > MAX_VERTS)
        begin
            n = NB'(MAX_VERTS);
        end
        else
        begin
            n = NB'(nv_reg);
        end
    end

    assign nm1  = VB'(n - NB'(1));
    assign n_sq = (2*NB)'(n) * (2*NB)'(n);
    assign w_in = WEIGHT_BITS'({{WEIGHT_BITS{1'b0}}, edge_weight_in});

    // candidate edge from the registered memory read
    assign eligible = tag_valid_reg && visited_reg[tag_i_reg] && !visited_reg[tag_j_reg]
                      && (rd_reg != '0)
                      && (CW'(rd_reg) < CW'(limit_reg));
    assign take     = eligible && (!found_reg || (rd_reg < best_w_reg));

    // saturating running cost
    assign sum      = SW'(cost_reg) + SW'(best_w_reg);
    assign cost_sat = (sum > SW'(pmd_pkg::COST_MAX)) ? pmd_pkg::COST_MAX
                                                     : pmd_pkg::COST_BITS'(sum);

    always_comb
    begin
        stat.load_final = (LW'(load_cnt_reg) + LW'(1)) >= LW'(n_sq);
        stat.bad_start  = int'(start_reg) >= int'(n);
        stat.scan_end   = (i_reg == nm1) && (j_reg == nm1);
        stat.found      = found_reg;
        stat.last_edge  = ((VB+1)'(edges_reg) + (VB+1)'(1)) == (VB+1)'(nm1);
        stat.out_free   = !res_valid_reg || !result_stall;
    end

    always_comb
    begin
        load_cnt_next  = load_cnt_reg;
        visited_next   = visited_reg;
        cost_next      = cost_reg;
        edges_next     = edges_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        addr_next      = addr_reg;
        found_next     = found_reg;
        best_i_next    = best_i_reg;
        best_j_next    = best_j_reg;
        best_w_next    = best_w_reg;
        res_valid_next = res_valid_reg && result_stall;

        if (cmd.load)
        begin
            load_cnt_next = stat.load_final ? '0 : load_cnt_reg + AB'(1);
        end

        if (take)
        begin
            found_next  = 1'b1;
            best_i_next = tag_i_reg;
            best_j_next = tag_j_reg;
            best_w_next = rd_reg;
        end

        if (cmd.issue)
        begin
            addr_next = addr_reg + AB'(1);
            if (j_reg == nm1)
            begin
                j_next = '0;
                i_next = i_reg + VB'(1);
            end
            else
            begin
                j_next = j_reg + VB'(1);
            end
        end

        if (cmd.init)
        begin
            visited_next = stat.bad_start ? '0
                                          : ({{(MAX_VERTS-1){1'b0}}, 1'b1} << start_reg);
            cost_next    = '0;
            edges_next   = '0;
            found_next   = 1'b0;
            i_next       = '0;
            j_next       = '0;
            addr_next    = '0;
        end

        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
            if (found_reg)
            begin
                visited_next[best_j_reg] = 1'b1;
                cost_next                = cost_sat;
                edges_next               = edges_reg + VB'(1);
            end
            found_next = 1'b0;
            i_next     = '0;
            j_next     = '0;
            addr_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg        <= pmd_pkg::NV_RESET;
            start_reg     <= pmd_pkg::START_RESET;
            limit_reg     <= pmd_pkg::LIMIT_RESET;
            load_cnt_reg  <= '0;
            visited_reg   <= '0;
            cost_reg      <= '0;
            edges_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            addr_reg      <= '0;
            tag_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pmd_pkg::REG_NUM_VERTICES: nv_reg    <= pmd_pkg::NV_BITS'(cfg_data);
                    pmd_pkg::REG_START_VERTEX: start_reg <= pmd_pkg::START_BITS'(cfg_data);
                    pmd_pkg::REG_WEIGHT_LIMIT: limit_reg <= pmd_pkg::LIMIT_BITS'(cfg_data);
                    default:                   ;
                endcase
            end
            load_cnt_reg  <= load_cnt_next;
            visited_reg   <= visited_next;
            cost_reg      <= cost_next;
            edges_reg     <= edges_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            addr_reg      <= addr_next;
            tag_valid_reg <= cmd.issue;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_i_reg <= best_i_next;
        best_j_reg <= best_j_next;
        best_w_reg <= best_w_next;
        if (cmd.issue)
        begin
            tag_i_reg <= i_reg;
            tag_j_reg <= j_reg;
        end
        if (cmd.emit)
        begin
            res_src_reg  <= found_reg ? pmd_pkg::VERT_BITS'(best_i_reg) : '0;
            res_dst_reg  <= found_reg ? pmd_pkg::VERT_BITS'(best_j_reg) : '0;
            res_w_reg    <= found_reg ? pmd_pkg::OUT_W_BITS'(best_w_reg) : '0;
            res_cost_reg <= found_reg ? cost_sat : cost_reg;
            res_unr_reg  <= !found_reg;
            res_last_reg <= !found_reg || stat.last_edge;
        end
    end

    // weight store, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[load_cnt_reg] <= w_in;
        end
        if (cmd.issue)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

    assign result_valid  = res_valid_reg;
    assign src_vertex    = res_src_reg;
    assign dst_vertex    = res_dst_reg;
    assign chosen_weight = res_w_reg;
    assign total_cost    = res_cost_reg;
    assign unreachable   = res_unr_reg;
    assign last          = res_last_reg;

endmodule

[rtl/prim_mst_dense_unit.sv]
// top level of the dense prim minimum spanning tree unit
// depends on pmd_pkg, pmd_ctrl and pmd_dp
//
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------
// item     | item_valid / item_stall| edge_weight_in
// result   | result_valid /         | src_vertex, dst_vertex, chosen_weight,
//          |   result_stall         |   total_cost, unreachable, last
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// matrix entries load at one request per cycle into the weight memory
// after the last entry a run takes a setup step, then per tree edge one memory
//   read per cycle over the whole matrix, one compare stage and one emit step
// a stalled result holds the scan at its emit step until the output frees up
// asynchronous active-low reset; the weight memory is not cleared
// input is stalled for the whole run; cfg writes are always taken
module prim_mst_dense_unit #(
    parameter int MAX_VERTS   = pmd_pkg::DEF_MAX_VERTS,
    parameter int WEIGHT_BITS = pmd_pkg::DEF_WEIGHT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pmd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [pmd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    // matrix entries, row-major
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [pmd_pkg::IN_BITS-1:0]       edge_weight_in,
    // tree edges
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [pmd_pkg::VERT_BITS-1:0]     src_vertex,
    output logic [pmd_pkg::VERT_BITS-1:0]     dst_vertex,
    output logic [pmd_pkg::OUT_W_BITS-1:0]    chosen_weight,
    output logic [pmd_pkg::COST_BITS-1:0]     total_cost,
    output logic                              unreachable,
    output logic                              last
);

    pmd_pkg::cmd_t  cmd;
    pmd_pkg::stat_t stat;

    // sequencer: load, setup, scan, tail compare, emit
    pmd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // weight memory, tree state and result register
    pmd_dp #(
        .MAX_VERTS   (MAX_VERTS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .edge_weight_in (edge_weight_in),
        .cmd            (cmd),
        .stat           (stat),
        .result_stall   (result_stall),
        .result_valid   (result_valid),
        .src_vertex     (src_vertex),
        .dst_vertex     (dst_vertex),
        .chosen_weight  (chosen_weight),
        .total_cost     (total_cost),
        .unreachable    (unreachable),
        .last           (last)
    );

endmodule
